// ===== hw/rtl/cuckoo_hash_table_engine_defines.svh =====
// assertion macros for the cuckoo hash table engine
// no dependencies
`ifndef CUCKOO_HASH_TABLE_ENGINE_DEFINES_SVH
`define CUCKOO_HASH_TABLE_ENGINE_DEFINES_SVH

// check a property on the rising clock edge, disabled in reset
`define CHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// check that a condition never holds on a rising clock edge out of reset
`define CHT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/cht_pkg.sv =====
// shared types and constants for the cuckoo hash table engine
// no dependencies
package cht_pkg;

  localparam int unsigned IndexBitsDef = 10;
  localparam int unsigned MaxKicksDef  = 16;

  localparam logic [2:0] OpLookup = 3'd0;
  localparam logic [2:0] OpInsert = 3'd1;
  localparam logic [2:0] OpInsAbs = 3'd2;
  localparam logic [2:0] OpUpdate = 3'd3;
  localparam logic [2:0] OpRemove = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StMiss    = 2'd1;
  localparam logic [1:0] StPresent = 2'd2;
  localparam logic [1:0] StNoSpace = 2'd3;

  localparam logic [1:0] RegMultZero = 2'd0;
  localparam logic [1:0] RegMultOne  = 2'd1;
  localparam logic [1:0] RegHashBits = 2'd2;
  localparam logic [1:0] RegKeyWords = 2'd3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_HWAIT, S_PRD0, S_PCHK0,
    S_IRD, S_ICHK, S_OUT
  } state_e;

  // hash request and reply between sequencer and hash unit
  typedef struct packed {
    logic        start;
    logic [63:0] key;
    logic [63:0] mult;
    logic        two_words;
  } hash_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] hash;
  } hash_rsp_t;

endpackage

// ===== hw/rtl/cht_hash.sv =====
// word-chained multiplicative hash, one 32x32 multiply per cycle
// depends on cht_pkg
module cht_hash (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cht_pkg::hash_req_t req_i,
  output cht_pkg::hash_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        word_q, word_d;
  logic        two_q, two_d;
  logic [63:0] key_q, key_d, mult_q, mult_d;
  logic [31:0] carry_q, carry_d;
  logic [31:0] hash_q, hash_d;
  logic        done_q, done_d;
  logic [63:0] prod;

  // shared multiplier
  assign prod = (word_q ? {32'd0, mult_q[63:32]} : {32'd0, mult_q[31:0]}) *
                (word_q ? {32'd0, key_q[63:32]} : {32'd0, key_q[31:0]})
                + {32'd0, carry_q};

  always_comb begin
    busy_d = busy_q; word_d = word_q; two_d = two_q; key_d = key_q;
    mult_d = mult_q; carry_d = carry_q; hash_d = hash_q; done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1; word_d = 1'b0; two_d = req_i.two_words;
      key_d = req_i.key; mult_d = req_i.mult; carry_d = '0;
    end else if (busy_q) begin
      carry_d = prod[63:32];
      if (word_q || !two_q) begin
        busy_d = 1'b0; done_d = 1'b1; hash_d = prod[31:0];
      end else begin
        word_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d; two_q <= two_d; key_q <= key_d; mult_q <= mult_d;
    carry_q <= carry_d; hash_q <= hash_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.hash = hash_q;

endmodule

// ===== hw/rtl/cuckoo_hash_table_engine.sv =====
// cuckoo hash table engine: two-table key/value store, one operation per beat
// a table step runs hash start, multiply and done, registered read, then check; probes use one or
// two steps, inserts two per displacement round for up to MAX_KICKS rounds; the result state
// follows and holds until taken, then idle; ready stays low until idle
// an unknown operation goes straight to the result state
// rst_ni async active low; a clearing pass over all 2**INDEX_BITS entries empties the valid bits
`include "cuckoo_hash_table_engine_defines.svh"
module cuckoo_hash_table_engine #(
  parameter int unsigned INDEX_BITS = cht_pkg::IndexBitsDef,
  parameter int unsigned MAX_KICKS  = cht_pkg::MaxKicksDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[2:0], lookup_key[66:3], new_value[98:67], zero pad to 104
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], found_value[33:2], occupancy[45:34], zero pad to 48
  output logic [47:0]  m_axis_tdata
);

  localparam int unsigned Depth = 1 << INDEX_BITS;
  localparam int unsigned KickW = $clog2(MAX_KICKS + 1);
  localparam int unsigned CntW  = INDEX_BITS + 2;

  cht_pkg::state_e state_q, state_d;

  logic [63:0] mz_q, mo_q;
  logic [3:0]  hb_q;
  logic [1:0]  kw_q;

  logic [63:0] kz_mem [Depth];
  logic [31:0] vz_mem [Depth];
  logic [63:0] ko_mem [Depth];
  logic [31:0] vo_mem [Depth];
  logic        vlz_mem [Depth];
  logic        vlo_mem [Depth];

  logic [2:0]  op_q;
  logic [63:0] key_q, key_d;
  logic [31:0] val_q, val_d;
  logic        tbl_q, tbl_d;
  logic [INDEX_BITS-1:0] idx_q, idx_d;
  logic [INDEX_BITS-1:0] clr_q;
  logic [KickW-1:0] kick_q, kick_d;
  logic [CntW-1:0] cnt_q;
  logic [1:0]  st_q, st_d;
  logic [31:0] fv_q, fv_d;

  logic [63:0] rk_q;
  logic [31:0] rv_q;
  logic        rvl_q;

  cht_pkg::hash_req_t hreq;
  cht_pkg::hash_rsp_t hrsp;

  cht_hash u_hash (.clk_i, .rst_ni, .req_i(hreq), .rsp_o(hrsp));

  // effective hash bits and index
  logic [3:0] eb;
  logic [INDEX_BITS-1:0] hidx;
  logic two_w, kmatch;
  always_comb begin
    eb = hb_q;
    if (eb == 4'd0) eb = 4'd1;
    if (32'(eb) > INDEX_BITS) eb = 4'(INDEX_BITS);
    hidx = INDEX_BITS'(hrsp.hash >> (6'd32 - {2'b0, eb}));
    two_w = kw_q[1];
    kmatch = (rk_q[31:0] == key_q[31:0]) && (!two_w || rk_q[63:32] == key_q[63:32]);
  end

  // configuration writes
  assign cfg_ready_o = (state_q == cht_pkg::S_IDLE);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mz_q <= 64'd1; mo_q <= 64'd3; hb_q <= 4'd10; kw_q <= 2'd2;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cht_pkg::RegMultZero: mz_q <= cfg_data_i;
        cht_pkg::RegMultOne:  mo_q <= cfg_data_i;
        cht_pkg::RegHashBits: hb_q <= cfg_data_i[3:0];
        cht_pkg::RegKeyWords: kw_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == cht_pkg::S_IDLE);
  assign m_axis_tvalid = (state_q == cht_pkg::S_OUT);
  assign m_axis_tdata = {2'b0, 12'(cnt_q), fv_q, st_q};

  // write controls
  logic wr_en, wr_key, set_vl, clr_vl, inc_c, dec_c, clr_run;

  // sequencer
  always_comb begin
    state_d = state_q; key_d = key_q; val_d = val_q; tbl_d = tbl_q;
    idx_d = idx_q; kick_d = kick_q; st_d = st_q; fv_d = fv_q;
    hreq.start = 1'b0; hreq.key = key_q; hreq.mult = tbl_q ? mo_q : mz_q;
    hreq.two_words = two_w;
    wr_en = 1'b0; wr_key = 1'b0; set_vl = 1'b0; clr_vl = 1'b0;
    inc_c = 1'b0; dec_c = 1'b0; clr_run = 1'b0;
    case (state_q)
      cht_pkg::S_CLR: begin
        // empty both tables one entry per cycle after reset
        clr_run = 1'b1;
        if (&clr_q) state_d = cht_pkg::S_IDLE;
      end
      cht_pkg::S_IDLE: begin
        if (in_acc) begin
          key_d = s_axis_tdata[66:3]; val_d = s_axis_tdata[98:67];
          tbl_d = 1'b0; kick_d = '0; st_d = cht_pkg::StMiss; fv_d = '0;
          state_d = cht_pkg::S_HASH;
        end
      end
      cht_pkg::S_HASH: begin
        if (op_q > cht_pkg::OpRemove) state_d = cht_pkg::S_OUT;
        else begin
          hreq.start = 1'b1; state_d = cht_pkg::S_HWAIT;
        end
      end
      cht_pkg::S_HWAIT: begin
        if (hrsp.done) begin
          idx_d = hidx;
          state_d = (op_q == cht_pkg::OpInsert || kick_q != '0 || st_q == cht_pkg::StOk)
                    ? cht_pkg::S_IRD : cht_pkg::S_PRD0;
        end
      end
      cht_pkg::S_PRD0: state_d = cht_pkg::S_PCHK0;
      cht_pkg::S_PCHK0: begin
        if (rvl_q && kmatch) begin
          case (op_q)
            cht_pkg::OpLookup: begin st_d = cht_pkg::StOk; fv_d = rv_q; end
            cht_pkg::OpInsAbs: st_d = cht_pkg::StPresent;
            cht_pkg::OpUpdate: begin st_d = cht_pkg::StOk; wr_en = 1'b1; end
            cht_pkg::OpRemove: begin st_d = cht_pkg::StOk; clr_vl = 1'b1; dec_c = 1'b1; end
            default: ;
          endcase
          state_d = cht_pkg::S_OUT;
        end else if (!tbl_q) begin
          tbl_d = 1'b1; state_d = cht_pkg::S_HASH;
        end else if (op_q == cht_pkg::OpInsAbs) begin
          // miss: fall into insert at table zero
          tbl_d = 1'b0; st_d = cht_pkg::StOk; state_d = cht_pkg::S_HASH;
        end else state_d = cht_pkg::S_OUT;
      end
      cht_pkg::S_IRD: state_d = cht_pkg::S_ICHK;
      cht_pkg::S_ICHK: begin
        wr_en = 1'b1; wr_key = 1'b1;
        if (!rvl_q) begin
          set_vl = 1'b1; inc_c = 1'b1; st_d = cht_pkg::StOk; state_d = cht_pkg::S_OUT;
        end else begin
          key_d = rk_q; val_d = rv_q;
          if (tbl_q && (32'(kick_q) + 1 >= MAX_KICKS)) begin
            st_d = cht_pkg::StNoSpace; state_d = cht_pkg::S_OUT;
          end else begin
            if (tbl_q) kick_d = kick_q + 1'b1;
            // mark insert phase so the hash result goes straight to the read
            st_d = cht_pkg::StOk;
            tbl_d = !tbl_q; state_d = cht_pkg::S_HASH;
          end
        end
      end
      cht_pkg::S_OUT: if (m_axis_tready) state_d = cht_pkg::S_IDLE;
      default: state_d = cht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::S_CLR; cnt_q <= '0; clr_q <= '0;
    end else begin
      state_q <= state_d;
      if (inc_c) cnt_q <= cnt_q + 1'b1;
      else if (dec_c) cnt_q <= cnt_q - 1'b1;
      if (clr_run) clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) op_q <= s_axis_tdata[2:0];
    key_q <= key_d; val_q <= val_d; tbl_q <= tbl_d; idx_q <= idx_d;
    kick_q <= kick_d; st_q <= st_d; fv_q <= fv_d;
  end

  // table memories, one read and one write port each
  always_ff @(posedge clk_i) begin
    if (wr_en && !tbl_q) begin
      vz_mem[idx_q] <= val_q;
      if (wr_key) kz_mem[idx_q] <= key_q;
    end
    if (wr_en && tbl_q) begin
      vo_mem[idx_q] <= val_q;
      if (wr_key) ko_mem[idx_q] <= key_q;
    end
    if (clr_run) begin
      vlz_mem[clr_q] <= 1'b0;
      vlo_mem[clr_q] <= 1'b0;
    end else begin
      if ((set_vl || clr_vl) && !tbl_q) vlz_mem[idx_q] <= set_vl;
      if ((set_vl || clr_vl) && tbl_q)  vlo_mem[idx_q] <= set_vl;
    end
    rk_q  <= tbl_q ? ko_mem[idx_q] : kz_mem[idx_q];
    rv_q  <= tbl_q ? vo_mem[idx_q] : vz_mem[idx_q];
    rvl_q <= tbl_q ? vlo_mem[idx_q] : vlz_mem[idx_q];
  end

  `CHT_NEVER(a_one_busy, s_axis_tready && m_axis_tvalid, "ready while result pending")
  `CHT_ASSERT(a_cnt_range, 32'(cnt_q) <= 2 * Depth, "entry count overflow")
  `CHT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata),
              "result changed while stalled")

endmodule
